>>> src/assert_macros.svh
// Assertion helpers for the block. Both forms sample on the rising edge of aclk.
// MDEPT_ASSERT is disabled while aresetn is low; MDEPT_ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MDEPT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define MDEPT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define MDEPT_ASSERT(name, prop, msg)

`define MDEPT_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

>>> src/mdept_pkg.sv
`timescale 1ns / 1ps

package mdept_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W    = 32;
    localparam int ELAPSED_W = 16;
    localparam int FACTOR_W  = 4;
    localparam int PROD_W    = DATA_W + FACTOR_W;
    localparam int CFG_ADDR_W = 2;

    // Defaults for the top-level parameters.
    localparam int HISTORY_LENGTH_DEF = 3;
    localparam int TIMER_WIDTH_DEF    = 32;

    // Reset values of the registers and of the startup timeout.
    localparam logic [FACTOR_W-1:0] FACTOR_RST      = 4'd3;
    localparam logic [DATA_W-1:0]   TIMEOUT_MIN_RST = 32'd10000000;
    localparam logic [DATA_W-1:0]   TIMEOUT_MAX_RST = 32'd60000000;
    localparam logic [DATA_W-1:0]   BOOT_TIMEOUT    = 32'd5000000;

    // Edge selection codes.
    localparam logic EDGE_RISING  = 1'b0;
    localparam logic EDGE_FALLING = 1'b1;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EDGE_MODE      = 2'd0,
        CFG_TIMEOUT_FACTOR = 2'd1,
        CFG_TIMEOUT_MIN    = 2'd2,
        CFG_TIMEOUT_MAX    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                 pin_level;
        logic [ELAPSED_W-1:0] elapsed_us;
    } in_t;

    typedef struct packed {
        logic              level_out;
        logic              level_changed;
        logic              edge_seen;
        logic [DATA_W-1:0] edge_count;
        logic [DATA_W-1:0] pulse_duration_us;
        logic              duration_valid;
    } out_t;

    // Configuration as seen by the timer.
    typedef struct packed {
        logic [FACTOR_W-1:0] timeout_factor;
        logic [DATA_W-1:0]   timeout_min_us;
        logic [DATA_W-1:0]   timeout_max_us;
    } cfg_t;

    // Filter status handed to the timer.
    typedef struct packed {
        logic level;
        logic changed;
        logic edge_hit;
    } filt_t;

    // Timer results for one beat.
    typedef struct packed {
        logic [DATA_W-1:0] edge_count;
        logic [DATA_W-1:0] pulse_duration_us;
        logic              duration_valid;
    } tmr_t;

endpackage

>>> src/mdept_filter.sv
`timescale 1ns / 1ps

module mdept_filter #(
    parameter int HISTORY_LENGTH = mdept_pkg::HISTORY_LENGTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            pin_level,
    input  logic            edge_mode,
    output mdept_pkg::filt_t filt
);
    import mdept_pkg::*;

    localparam int CNT_W = $clog2(HISTORY_LENGTH + 1);

    logic [HISTORY_LENGTH-1:0] hist_reg;
    logic [HISTORY_LENGTH-1:0] hist_next;
    logic                      level_reg;
    logic [CNT_W-1:0]          ones;
    logic                      level;

    // Shift the new sample in and take the majority of the window.
    always_comb begin
        hist_next = (hist_reg << 1) | HISTORY_LENGTH'(pin_level);
        ones = '0;
        for (int i = 0; i < HISTORY_LENGTH; i++) begin
            ones = ones + CNT_W'(hist_next[i]);
        end
        level = (ones > CNT_W'(HISTORY_LENGTH / 2));
    end

    // Report the change and whether it is the selected edge.
    always_comb begin
        filt.level    = level;
        filt.changed  = (level != level_reg);
        filt.edge_hit = filt.changed &&
                        ((edge_mode == EDGE_RISING && level) ||
                         (edge_mode == EDGE_FALLING && !level));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            level_reg <= 1'b0;
        end else if (advance) begin
            hist_reg  <= hist_next;
            level_reg <= level;
        end
    end

endmodule

>>> src/mdept_timer.sv
`timescale 1ns / 1ps

module mdept_timer #(
    parameter int TIMER_WIDTH = mdept_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  logic [mdept_pkg::ELAPSED_W-1:0]     elapsed_us,
    input  mdept_pkg::filt_t                    filt,
    input  mdept_pkg::cfg_t                     cfg,
    output mdept_pkg::tmr_t                     tmr
);
    import mdept_pkg::*;

    localparam int TSUM_W = TIMER_WIDTH + 1;

    logic [TIMER_WIDTH-1:0] timer_reg;
    logic [TIMER_WIDTH-1:0] timer_next;
    logic [DATA_W-1:0]      edges_reg;
    logic [DATA_W-1:0]      edges_next;
    logic [DATA_W-1:0]      last_reg;
    logic [DATA_W-1:0]      last_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic [DATA_W-1:0]      left_reg;
    logic [DATA_W-1:0]      left_next;
    logic                   armed_reg;
    logic                   armed_next;

    logic [TSUM_W-1:0]      timer_sum;
    logic [TIMER_WIDTH-1:0] timer_adv;
    logic [DATA_W-1:0]      elapsed_ext;
    logic                   expire;
    logic [PROD_W-1:0]      product;
    logic [PROD_W-1:0]      clamp_lo;

    // Saturating interval timer and one-shot timeout countdown.
    always_comb begin
        timer_sum   = {1'b0, timer_reg} + TSUM_W'(elapsed_us);
        timer_adv   = timer_sum[TIMER_WIDTH] ? '1 : timer_sum[TIMER_WIDTH-1:0];
        elapsed_ext = DATA_W'(elapsed_us);
        expire      = armed_reg && (elapsed_ext >= left_reg);
    end

    // Expiry first, then the selected edge latches the interval and re-arms.
    always_comb begin
        timer_next = timer_adv;
        edges_next = edges_reg;
        last_next  = expire ? '0 : last_reg;
        valid_next = expire ? 1'b0 : valid_reg;
        armed_next = armed_reg && !expire;
        if (expire) begin
            left_next = '0;
        end else if (armed_reg) begin
            left_next = left_reg - elapsed_ext;
        end else begin
            left_next = left_reg;
        end

        product  = PROD_W'(DATA_W'(timer_adv)) * PROD_W'(cfg.timeout_factor);
        clamp_lo = (product < PROD_W'(cfg.timeout_min_us)) ?
                   PROD_W'(cfg.timeout_min_us) : product;

        if (filt.edge_hit) begin
            edges_next = edges_reg + 1'b1;
            last_next  = DATA_W'(timer_adv);
            valid_next = 1'b1;
            timer_next = '0;
            armed_next = 1'b1;
            left_next  = (clamp_lo > PROD_W'(cfg.timeout_max_us)) ?
                         cfg.timeout_max_us : clamp_lo[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            edges_reg <= '0;
            last_reg  <= '0;
            valid_reg <= 1'b0;
            left_reg  <= BOOT_TIMEOUT;
            armed_reg <= 1'b1;
        end else if (advance) begin
            timer_reg <= timer_next;
            edges_reg <= edges_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
            left_reg  <= left_next;
            armed_reg <= armed_next;
        end
    end

    always_comb begin
        tmr.edge_count        = edges_next;
        tmr.pulse_duration_us = last_next;
        tmr.duration_valid    = valid_next;
    end

endmodule

>>> src/majority_debounce_edge_period_timer_unit.sv
`timescale 1ns / 1ps
// Majority-vote debouncer with edge period timer.
// Input channel (s_valid/s_ready/s_data): one beat per sampling tick, carrying the
// raw pin level and the microseconds since the previous tick. Output channel
// (m_valid/m_ready/m_data): exactly one result beat per input beat, in order, with
// the filtered level, change and edge flags, edge count and the latest interval.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr at the clock edge;
// write only while no beat is in flight.
// The accepted beat sits in the input register; when the result register is free,
// the filter and timer update and load the result register, which raises m_valid.
// Throughput is one beat per cycle while the receiver keeps m_ready high; the limit
// is the combinational state update of the timer (saturating add, 32x4 multiply and clamp).
// When the receiver stalls, the result register holds and the input register can
// still take one more beat; after that s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both registers, clears the filter and
// counters, restores the register defaults and arms the startup timeout.
module majority_debounce_edge_period_timer_unit #(
    parameter int HISTORY_LENGTH = mdept_pkg::HISTORY_LENGTH_DEF,
    parameter int TIMER_WIDTH    = mdept_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mdept_pkg::in_t                   s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mdept_pkg::out_t                  m_data,
    input  logic                             cfg_wr_en,
    input  logic [mdept_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mdept_pkg::DATA_W-1:0]     cfg_wdata
);
    import mdept_pkg::*;

    `include "assert_macros.svh"

    logic                in_valid_reg;
    in_t                 in_data_reg;
    logic                out_valid_reg;
    out_t                out_data_reg;
    logic                advance;

    logic                edge_mode_reg;
    cfg_t                cfg_reg;

    filt_t               filt;
    tmr_t                tmr;

    // Beat moves from the input register to the result register.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_mode_reg          <= EDGE_RISING;
            cfg_reg.timeout_factor <= FACTOR_RST;
            cfg_reg.timeout_min_us <= TIMEOUT_MIN_RST;
            cfg_reg.timeout_max_us <= TIMEOUT_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_EDGE_MODE:      edge_mode_reg          <= cfg_wdata[0];
                CFG_TIMEOUT_FACTOR: cfg_reg.timeout_factor <= cfg_wdata[FACTOR_W-1:0];
                CFG_TIMEOUT_MIN:    cfg_reg.timeout_min_us <= cfg_wdata;
                CFG_TIMEOUT_MAX:    cfg_reg.timeout_max_us <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    mdept_filter #(
        .HISTORY_LENGTH (HISTORY_LENGTH)
    ) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .pin_level (in_data_reg.pin_level),
        .edge_mode (edge_mode_reg),
        .filt      (filt)
    );

    mdept_timer #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .elapsed_us (in_data_reg.elapsed_us),
        .filt       (filt),
        .cfg        (cfg_reg),
        .tmr        (tmr)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg.level_out         <= filt.level;
            out_data_reg.level_changed     <= filt.changed;
            out_data_reg.edge_seen         <= filt.edge_hit;
            out_data_reg.edge_count        <= tmr.edge_count;
            out_data_reg.pulse_duration_us <= tmr.pulse_duration_us;
            out_data_reg.duration_valid    <= tmr.duration_valid;
        end
    end

    // A held input beat must not pass while the result register is stalled.
    `MDEPT_ASSERT(a_no_pass_on_stall, (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready, "input taken while both registers are full")
    // The selected edge is always a level change.
    `MDEPT_ASSERT(a_edge_is_change, m_valid |-> (!m_data.edge_seen || m_data.level_changed), "edge reported without a level change")
    // An edge latches a fresh interval, so the next result shows it valid.
    `MDEPT_ASSERT(a_edge_validates, (advance && filt.edge_hit) |=> (m_valid && m_data.duration_valid), "edge did not validate the interval")
    // Reset empties the result register.
    `MDEPT_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

>>> tb/tb_majority_debounce_edge_period_timer_unit.sv
`timescale 1ns / 1ps

module tb_majority_debounce_edge_period_timer_unit;
    import mdept_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_PAUSE  = 4;
    localparam int STALL_LIMIT  = 4000;
    localparam int LOW_TICKS    = 40;

    // Clock, reset and the ports of the block.
    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_t      s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_t     m_data;
    logic     cfg_wr_en = 1'b0;
    cfg_idx_t cfg_addr = CFG_EDGE_MODE;
    logic [DATA_W-1:0] cfg_wdata = '0;

    majority_debounce_edge_period_timer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Register copies as the debouncer sees them.
    logic                sel_edge   = EDGE_RISING;
    logic [FACTOR_W-1:0] tmo_factor = FACTOR_RST;
    logic [DATA_W-1:0]   tmo_min    = TIMEOUT_MIN_RST;
    logic [DATA_W-1:0]   tmo_max    = TIMEOUT_MAX_RST;

    // Debouncer and period timer state, at reset values.
    logic [2:0]        samples       = '0;
    logic              debounced     = 1'b0;
    logic [DATA_W-1:0] edge_tally    = '0;
    logic [DATA_W-1:0] since_edge_us = '0;
    logic [DATA_W-1:0] held_interval = '0;
    logic              held_valid    = 1'b0;
    logic [DATA_W-1:0] expiry_left   = BOOT_TIMEOUT;
    logic              expiry_armed  = 1'b1;

    out_t expected_beats[$];
    int   mismatches = 0;
    int   beats_seen = 0;
    int   ticks_sent = 0;

    // Controls of the sender and the receiver.
    bit idle_on      = 1'b1;
    bit quiet        = 1'b0;
    bit hold_off_req = 1'b0;

    // Random pin waveform: runs of one level with occasional glitches.
    logic run_level = 1'b0;
    int   run_left  = 0;

    // One row of the directed table: a register write or a tick.
    typedef struct {
        bit                is_reg;
        cfg_idx_t          idx;
        logic [DATA_W-1:0] val;
        in_t               tick;
        bit                zero_expected;
    } plan_row_t;

    plan_row_t directed_plan[$];

    // Advances the debouncer by one tick and returns the result it reports.
    function automatic out_t predict_tick(in_t t);
        logic [DATA_W:0]   sum;
        logic [PROD_W-1:0] span;
        logic              lvl;
        logic              chg;
        logic              hit;
        out_t              r;

        // The interval timer sticks at all ones.
        sum = {1'b0, since_edge_us} + (DATA_W + 1)'(t.elapsed_us);
        since_edge_us = sum[DATA_W] ? '1 : sum[DATA_W-1:0];

        // One-shot timeout; when it runs out, the held interval is dropped.
        if (expiry_armed) begin
            if (DATA_W'(t.elapsed_us) >= expiry_left) begin
                expiry_left   = '0;
                expiry_armed  = 1'b0;
                held_interval = '0;
                held_valid    = 1'b0;
            end else begin
                expiry_left = expiry_left - DATA_W'(t.elapsed_us);
            end
        end

        // Two of the last three samples decide the level.
        samples = {samples[1:0], t.pin_level};
        lvl = (samples[0] & samples[1]) | (samples[0] & samples[2]) |
              (samples[1] & samples[2]);
        chg = (lvl != debounced);
        // A rising edge ends at level 1 and a falling one at level 0.
        hit = chg && (lvl != sel_edge);

        // Latch the interval and re-arm the timeout with min then max clamp.
        if (hit) begin
            edge_tally    = edge_tally + 1'b1;
            held_interval = since_edge_us;
            held_valid    = 1'b1;
            since_edge_us = '0;
            span = PROD_W'(held_interval) * PROD_W'(tmo_factor);
            if (span < PROD_W'(tmo_min)) span = PROD_W'(tmo_min);
            if (span > PROD_W'(tmo_max)) span = PROD_W'(tmo_max);
            expiry_left  = span[DATA_W-1:0];
            expiry_armed = 1'b1;
        end
        debounced = lvl;

        r.level_out         = lvl;
        r.level_changed     = chg;
        r.edge_seen         = hit;
        r.edge_count        = edge_tally;
        r.pulse_duration_us = held_interval;
        r.duration_valid    = held_valid;
        return r;
    endfunction

    function automatic in_t random_tick();
        in_t t;

        if (run_left == 0) begin
            run_level = ~run_level;
            run_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 10);
        end
        run_left--;
        t.pin_level = ($urandom_range(0, 7) == 0) ? ~run_level : run_level;
        case ($urandom_range(0, 9))
            0: t.elapsed_us = '0;
            1: t.elapsed_us = '1;
            2: t.elapsed_us = ELAPSED_W'($urandom_range(0, 65535));
            default: t.elapsed_us = ELAPSED_W'($urandom_range(1, 3000));
        endcase
        return t;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t, result beat %0d: %s", $realtime, beats_seen, msg);
    endtask

    task automatic check_beat(out_t got, out_t want);
        if (got.level_out !== want.level_out)
            report_mismatch($sformatf("level_out %0d, expected %0d",
                                      got.level_out, want.level_out));
        if (got.level_changed !== want.level_changed)
            report_mismatch($sformatf("level_changed %0d, expected %0d",
                                      got.level_changed, want.level_changed));
        if (got.edge_seen !== want.edge_seen)
            report_mismatch($sformatf("edge_seen %0d, expected %0d",
                                      got.edge_seen, want.edge_seen));
        if (got.edge_count !== want.edge_count)
            report_mismatch($sformatf("edge_count %0d, expected %0d",
                                      got.edge_count, want.edge_count));
        if (got.pulse_duration_us !== want.pulse_duration_us)
            report_mismatch($sformatf("pulse_duration_us %0d, expected %0d",
                                      got.pulse_duration_us, want.pulse_duration_us));
        if (got.duration_valid !== want.duration_valid)
            report_mismatch($sformatf("duration_valid %0d, expected %0d",
                                      got.duration_valid, want.duration_valid));
    endtask

    task automatic add_tick(logic pin, logic [ELAPSED_W-1:0] el, bit zero_expected = 1'b0);
        plan_row_t r;

        r.is_reg           = 1'b0;
        r.idx              = CFG_EDGE_MODE;
        r.val              = '0;
        r.tick.pin_level   = pin;
        r.tick.elapsed_us  = el;
        r.zero_expected    = zero_expected;
        directed_plan.push_back(r);
    endtask

    task automatic add_reg(cfg_idx_t idx, logic [DATA_W-1:0] val);
        plan_row_t r;

        r.is_reg        = 1'b1;
        r.idx           = idx;
        r.val           = val;
        r.tick          = '0;
        r.zero_expected = 1'b0;
        directed_plan.push_back(r);
    endtask

    // Offers one tick, holds it until accepted, and queues its expected result.
    task automatic send_tick(in_t t, bit zero_expected);
        out_t pred;

        if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = predict_tick(t);
        if (zero_expected) pred = '0;
        expected_beats.push_back(pred);
        ticks_sent++;
        if (ticks_sent % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
    endtask

    // Stops offering and waits until every queued result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_EDGE_MODE:      sel_edge   = val[0];
            CFG_TIMEOUT_FACTOR: tmo_factor = val[FACTOR_W-1:0];
            CFG_TIMEOUT_MIN:    tmo_min    = val;
            CFG_TIMEOUT_MAX:    tmo_max    = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setting(logic mode, logic [FACTOR_W-1:0] factor,
                                 logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
        wait_drained();
        write_reg(CFG_EDGE_MODE, DATA_W'(mode));
        write_reg(CFG_TIMEOUT_FACTOR, DATA_W'(factor));
        write_reg(CFG_TIMEOUT_MIN, lo);
        write_reg(CFG_TIMEOUT_MAX, hi);
    endtask

    task automatic run_phase(int n);
        repeat (n) send_tick(random_tick(), 1'b0);
    endtask

    // Result checker: every accepted beat is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_beats.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
                check_beat(m_data, expected_beats.pop_front());
        end
    end

    // Receiver: random stalls, one long hold-off on request, steady when idling is off.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    initial begin
        int stalled;

        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, wide clamp run.
    initial begin
        bit prev_reg;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values read all zeros on the first two ticks.
        add_tick(1'b0, '0, 1'b1);
        add_tick(1'b1, '1, 1'b1);
        add_tick(1'b1, 16'd100);
        add_tick(1'b0, 16'd0);
        // A single high sample between lows keeps the level high while two of the last three samples are high.
        add_tick(1'b1, 16'd0);
        add_tick(1'b0, 16'd0);
        add_tick(1'b0, '1);
        add_tick(1'b1, 16'd0);
        add_tick(1'b1, 16'd1);
        // Zero factor with a fixed timeout of ten microseconds.
        add_reg(CFG_TIMEOUT_FACTOR, 32'd0);
        add_reg(CFG_TIMEOUT_MIN, 32'd10);
        add_reg(CFG_TIMEOUT_MAX, 32'd10);
        add_tick(1'b0, 16'd0);
        add_tick(1'b0, 16'd0);
        add_tick(1'b1, 16'd0);
        add_tick(1'b1, 16'd10);
        // The timeout runs out on the same tick as the next edge.
        add_tick(1'b0, 16'd0);
        add_tick(1'b0, 16'd0);
        add_tick(1'b1, 16'd0);
        add_tick(1'b1, 16'd10);
        // Plain expiry with no edge.
        add_tick(1'b1, 16'd10);
        // A zero timeout runs out on the next tick even with no time elapsed.
        add_reg(CFG_TIMEOUT_MIN, 32'd0);
        add_reg(CFG_TIMEOUT_MAX, 32'd0);
        add_tick(1'b0, 16'd0);
        add_tick(1'b0, 16'd0);
        add_tick(1'b1, 16'd0);
        add_tick(1'b1, 16'd0);
        add_tick(1'b1, 16'd0);
        // Falling edges with crossed clamps, where the upper one wins.
        add_reg(CFG_EDGE_MODE, DATA_W'(EDGE_FALLING));
        add_reg(CFG_TIMEOUT_FACTOR, 32'd15);
        add_reg(CFG_TIMEOUT_MIN, 32'd500);
        add_reg(CFG_TIMEOUT_MAX, 32'd100);
        add_tick(1'b0, 16'd7);
        add_tick(1'b0, '1);

        prev_reg = 1'b0;
        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_reg) begin
                if (!prev_reg) wait_drained();
                write_reg(directed_plan[i].idx, directed_plan[i].val);
            end else begin
                send_tick(directed_plan[i].tick, directed_plan[i].zero_expected);
            end
            prev_reg = directed_plan[i].is_reg;
        end

        // Random phases over several settings; the first one starts with a long
        // receiver hold-off so that the block fills and stalls its input.
        apply_setting(EDGE_FALLING, 4'd15, 32'd0, 32'd200000);
        quiet        = 1'b1;
        hold_off_req = 1'b1;
        run_phase(300);
        apply_setting(EDGE_RISING, 4'd1, '1, '1);
        run_phase(200);
        apply_setting(EDGE_FALLING, 4'd0, 32'd50000, 32'd30000);
        run_phase(120);
        wait_drained();
        run_phase(130);
        apply_setting(EDGE_RISING, 4'd7, 32'd0, 32'd0);
        run_phase(250);
        apply_setting(EDGE_FALLING, 4'd2, 32'd1000, 32'd400000);
        run_phase(300);

        // Last part runs without idling.
        idle_on = 1'b0;
        apply_setting(EDGE_RISING, 4'd3, 32'd2000, 32'd90000);
        run_phase(200);

        // Hold the pin low for a long interval, then take a rising edge with the
        // widest clamp range and the largest factor.
        apply_setting(EDGE_RISING, 4'd15, 32'd0, '1);
        for (int i = 0; i < LOW_TICKS; i++) send_tick('{pin_level: 1'b0, elapsed_us: '1}, 1'b0);
        send_tick('{pin_level: 1'b1, elapsed_us: 16'd5}, 1'b0);
        send_tick('{pin_level: 1'b1, elapsed_us: 16'd5}, 1'b0);
        send_tick('{pin_level: 1'b0, elapsed_us: 16'd0}, 1'b0);
        send_tick('{pin_level: 1'b0, elapsed_us: '1}, 1'b0);

        wait_drained();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
